@@ src/bafen_pkg.sv @@
// Package: widths, flag and datapath types, and the CORDIC arctangent table.
`default_nettype none
package bafen_pkg;

  localparam int unsigned COMP_W       = 16;  // input component width
  localparam int unsigned BEARING_W    = 16;  // output binary angle width
  localparam int unsigned MAG_W        = COMP_W + 1;  // magnitude holds 2^15
  localparam int unsigned PRESHIFT     = 16;
  localparam int unsigned X_W          = MAG_W + PRESHIFT + 3;  // CORDIC gain headroom
  localparam int unsigned Z_W          = 32;  // fine angle, 2^31 units equal pi
  localparam int unsigned ANG_W        = 34;  // unfolded angle, holds -pi..pi plus rounding
  localparam int unsigned ATAN_N       = 24;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  localparam logic signed [ANG_W-1:0] FINE_PI      = ANG_W'(64'sd2147483648);
  localparam logic signed [ANG_W-1:0] FINE_HALF_PI = ANG_W'(64'sd1073741824);
  localparam logic signed [Z_W-1:0]   FINE_QUARTER = 32'sh2000_0000;
  localparam logic signed [ANG_W-1:0] ROUND_HALF   = ANG_W'(64'sd32768);

  // atan(2^-i) in fine units.
  localparam logic signed [Z_W-1:0] ATAN_STEP [ATAN_N] = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
    32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
    32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
    32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
    32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
    32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
  };

  // Folding flags that ride along with the vector through the pipeline.
  typedef struct packed {
    logic east_pos;
    logic north_pos;
    logic swapped;
    logic big_zero;
    logic small_zero;
  } octant_t;

  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic signed [Z_W-1:0] z;
    octant_t               oct;
  } cordic_t;

endpackage
`default_nettype wire

@@ src/bafen_if.sv @@
// Interfaces: the vector request channel and the bearing result channel.
`default_nettype none
interface bafen_vec_if;
  import bafen_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COMP_W-1:0] east_component;
  logic signed [COMP_W-1:0] north_component;

  modport source (output valid, output east_component, output north_component, input ready);
  modport sink   (input valid, input east_component, input north_component, output ready);
endinterface

interface bafen_bearing_if;
  import bafen_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [BEARING_W-1:0] bearing;

  modport source (output valid, output bearing, input ready);
  modport sink   (input valid, input bearing, output ready);
endinterface
`default_nettype wire

@@ src/bafen_fold.sv @@
// Fold stage: magnitudes, octant swap, special-case flags, CORDIC seed.
`default_nettype none
module bafen_fold (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             valid_i,
  output logic                                  ready_o,
  input  wire logic signed [bafen_pkg::COMP_W-1:0] east_i,
  input  wire logic signed [bafen_pkg::COMP_W-1:0] north_i,
  output logic                                  valid_o,
  input  wire logic                             ready_i,
  output bafen_pkg::cordic_t                    data_o
);
  import bafen_pkg::*;

  logic signed [MAG_W-1:0] east_ext, north_ext;
  logic        [MAG_W-1:0] east_mag, north_mag, small_mag, big_mag;
  logic                    swap;
  cordic_t                 data_d, data_q;
  logic                    valid_q;

  always_comb begin
    east_ext  = MAG_W'(east_i);
    north_ext = MAG_W'(north_i);
    east_mag  = east_ext[MAG_W-1] ? MAG_W'(-east_ext) : MAG_W'(east_ext);
    north_mag = north_ext[MAG_W-1] ? MAG_W'(-north_ext) : MAG_W'(north_ext);
    swap      = east_mag > north_mag;
    small_mag = swap ? north_mag : east_mag;
    big_mag   = swap ? east_mag : north_mag;

    data_d.x              = $signed({3'b000, big_mag, PRESHIFT'(0)});
    data_d.y              = $signed({3'b000, small_mag, PRESHIFT'(0)});
    data_d.z              = '0;
    data_d.oct.east_pos   = !east_i[COMP_W-1] && (east_i != '0);
    data_d.oct.north_pos  = !north_i[COMP_W-1] && (north_i != '0);
    data_d.oct.swapped    = swap;
    data_d.oct.big_zero   = big_mag == '0;
    data_d.oct.small_zero = small_mag == '0;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

@@ src/bafen_cordic_stage.sv @@
// One vectoring CORDIC iteration with its own pipeline register.
`default_nettype none
module bafen_cordic_stage #(
  parameter int unsigned STEP = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire bafen_pkg::cordic_t data_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output bafen_pkg::cordic_t data_o
);
  import bafen_pkg::*;

  logic signed [X_W-1:0] dx, dy;
  logic                  y_pos;
  cordic_t               data_d, data_q;
  logic                  valid_q;

  always_comb begin
    // Arithmetic shifts round toward minus infinity.
    dx     = data_i.y >>> STEP;
    dy     = data_i.x >>> STEP;
    y_pos  = !data_i.y[X_W-1] && (data_i.y != '0);
    data_d = data_i;
    if (y_pos) begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + ATAN_STEP[STEP];
    end else begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - ATAN_STEP[STEP];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

@@ src/bafen_unfold.sv @@
// Unfold stages: clamp and octant restore, then quadrant restore and rounding.
`default_nettype none
module bafen_unfold (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               valid_i,
  output logic                                    ready_o,
  input  wire logic signed [bafen_pkg::Z_W-1:0]   z_i,
  input  wire bafen_pkg::octant_t                 oct_i,
  output logic                                    valid_o,
  input  wire logic                               ready_i,
  output logic signed [bafen_pkg::BEARING_W-1:0]  bearing_o
);
  import bafen_pkg::*;

  // First stage: angle inside the first quadrant.
  logic signed [Z_W-1:0]   z_clamp;
  logic signed [ANG_W-1:0] oct_ang, quad_ang_d;
  logic signed [ANG_W-1:0] quad_ang_q;
  logic                    east_pos_q, north_pos_q;
  logic                    a_valid_q, a_ready;

  // Second stage: signed angle rounded to the binary angle.
  logic signed [ANG_W-1:0]     full_ang, rounded;
  logic signed [BEARING_W-1:0] bearing_q;
  logic                        b_valid_q;

  always_comb begin
    if (z_i[Z_W-1]) begin
      z_clamp = '0;
    end else if (z_i > FINE_QUARTER) begin
      z_clamp = FINE_QUARTER;
    end else begin
      z_clamp = z_i;
    end
    if (oct_i.big_zero) begin
      oct_ang = FINE_HALF_PI;
    end else if (oct_i.small_zero) begin
      oct_ang = '0;
    end else begin
      oct_ang = ANG_W'(z_clamp);
    end
    quad_ang_d = oct_i.swapped ? FINE_HALF_PI - oct_ang : oct_ang;
  end

  assign ready_o = !a_valid_q || a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (ready_o) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      quad_ang_q  <= quad_ang_d;
      east_pos_q  <= oct_i.east_pos;
      north_pos_q <= oct_i.north_pos;
    end
  end

  always_comb begin
    if (north_pos_q && !east_pos_q) begin
      full_ang = -quad_ang_q;
    end else if (!north_pos_q && !east_pos_q) begin
      full_ang = quad_ang_q - FINE_PI;
    end else if (!north_pos_q && east_pos_q) begin
      full_ang = FINE_PI - quad_ang_q;
    end else begin
      full_ang = quad_ang_q;
    end
    // Round to nearest, ties up; plus pi wraps to minus pi by truncation.
    rounded = full_ang + ROUND_HALF;
  end

  assign a_ready = !b_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (a_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && a_ready) begin
      bearing_q <= rounded[PRESHIFT +: BEARING_W];
    end
  end

  assign valid_o   = b_valid_q;
  assign bearing_o = bearing_q;
endmodule
`default_nettype wire

@@ src/bearing_angle_from_east_north_unit.sv @@
// Top level: pipelined CORDIC bearing (atan2 of east over north) unit.
//
//  Channel    Direction  Handshake     Payload
//  vec_i      in         valid/ready   east_component, north_component (s16 each)
//  bearing_o  out        valid/ready   bearing (s16, 32768 units equal pi)
//
// One request is taken per cycle while no stall backs up to vec_i; the pipeline holds one
// fold stage, one register per CORDIC iteration, and two unfold stages.
// Reset clears only the valid bits of every stage; payload registers hold junk.
// Each stage advances when it is empty or its successor takes its contents, so
// a stall on bearing_o backs up stage by stage and bubbles are squeezed out;
// vec_i.ready drops only when every stage holds a request.
`default_nettype none
module bearing_angle_from_east_north_unit #(
  parameter int unsigned CORDIC_STEPS = bafen_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  bafen_vec_if.sink      vec_i,
  bafen_bearing_if.source bearing_o
);
  import bafen_pkg::*;

  // Index 0 is the fold output; index k is the output of CORDIC iteration k-1.
  logic    [CORDIC_STEPS:0] stage_valid;
  logic    [CORDIC_STEPS:0] stage_ready;
  cordic_t                  stage_data [CORDIC_STEPS+1];

  bafen_fold u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vec_i.valid),
    .ready_o (vec_i.ready),
    .east_i  (vec_i.east_component),
    .north_i (vec_i.north_component),
    .valid_o (stage_valid[0]),
    .ready_i (stage_ready[0]),
    .data_o  (stage_data[0])
  );

  // The iteration index sets both the shift and the arctangent constant.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    bafen_cordic_stage #(
      .STEP (i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[i]),
      .ready_o (stage_ready[i]),
      .data_i  (stage_data[i]),
      .valid_o (stage_valid[i+1]),
      .ready_i (stage_ready[i+1]),
      .data_o  (stage_data[i+1])
    );
  end

  bafen_unfold u_unfold (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (stage_valid[CORDIC_STEPS]),
    .ready_o   (stage_ready[CORDIC_STEPS]),
    .z_i       (stage_data[CORDIC_STEPS].z),
    .oct_i     (stage_data[CORDIC_STEPS].oct),
    .valid_o   (bearing_o.valid),
    .ready_i   (bearing_o.ready),
    .bearing_o (bearing_o.bearing)
  );

`ifndef SYNTHESIS
  // The input stalls only when the whole CORDIC chain is occupied.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vec_i.ready |-> (&stage_valid))
    else $error("input stalled while a pipeline stage was empty");

  // An accepted request lands in the fold register on the next cycle.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vec_i.valid && vec_i.ready) |=> stage_valid[0])
    else $error("accepted request did not reach the fold stage");

  // A last-iteration result held back by the unfold stages stays put.
  a_cordic_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid[CORDIC_STEPS] && !stage_ready[CORDIC_STEPS]) |=>
      (stage_valid[CORDIC_STEPS] && $stable(stage_data[CORDIC_STEPS])))
    else $error("stalled CORDIC output changed or was dropped");
`endif

endmodule
`default_nettype wire
